// ----- rtl/core/s_star_haplotype_score_top_assert.svh -----
// Assertion macros for the S* score block.
`ifndef S_STAR_HAPLOTYPE_SCORE_TOP_ASSERT_SVH
`define S_STAR_HAPLOTYPE_SCORE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define SSH_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error("%m");
`else
`define SSH_ASSERT(label, clk, rst_n, prop)
`define SSH_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/core/ssh_pkg.sv -----
package ssh_pkg;
  localparam int unsigned ScoreW = 48;
  localparam int unsigned PosW = 32;
  localparam int unsigned GenoW = 2;
  localparam int unsigned BonusW = 20;
  localparam int unsigned PenW = 21;
  localparam int unsigned MinDist = 10;
  localparam int unsigned SeedFactor = 10;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SEED, ST_RDK, ST_RDJ, ST_EXT, ST_NEW, ST_WRK,
    ST_BEST, ST_BESTCHK, ST_EMIT_RD, ST_EMIT
  } state_e;

  typedef enum logic [0:0] {
    REG_BONUS = 1'b0,
    REG_PENALTY = 1'b1
  } reg_idx_e;

  // Pair evaluation result handed from the pair unit to the sequencer.
  typedef struct packed {
    logic               valid;
    logic signed [ScoreW-1:0] pair;
  } pair_t;
endpackage

// ----- rtl/core/ssh_pair_unit.sv -----
module ssh_pair_unit (
  input  logic [ssh_pkg::PosW-1:0]      pos_k_i,
  input  logic [ssh_pkg::PosW-1:0]      pos_j_i,
  input  logic [ssh_pkg::GenoW-1:0]     geno_k_i,
  input  logic [ssh_pkg::GenoW-1:0]     geno_j_i,
  input  logic [ssh_pkg::BonusW-1:0]    bonus_i,
  input  logic signed [ssh_pkg::PenW-1:0] penalty_i,
  output ssh_pkg::pair_t                pair_o
);
  import ssh_pkg::*;

  logic signed [PosW:0] pos_diff;
  logic [GenoW-1:0] gx;

  always_comb begin
    pos_diff = $signed({1'b0, pos_k_i}) - $signed({1'b0, pos_j_i});
    gx = geno_k_i ^ geno_j_i;
    pair_o.valid = (pos_diff >= $signed((PosW+1)'(MinDist)));
    if (gx == 2'b00 || gx == 2'b11) begin
      pair_o.pair = ScoreW'($signed({1'b0, bonus_i})) + ScoreW'(pos_diff);
    end else begin
      pair_o.pair = ScoreW'(penalty_i);
    end
  end
endmodule

// ----- rtl/core/s_star_haplotype_score_top.sv -----
// S* haplotype score: SNP words load at one per cycle; the word flagged last starts the DP.
// For N SNPs: a seed write each, a fetch of SNP 0, for each later SNP k a fetch, k pairs
// (read, evaluate, update) and a score write, a best-score search, then a read and emit per
// SNP plus any output stall; the input is not ready from the last word until output is done.
// One shared pair/add/compare unit and one memory read address per cycle serialise the work.
// Reset (async, active low) restores bonus 5000, penalty -10000 and an empty window.
module s_star_haplotype_score_top #(
  parameter int unsigned MAX_SNPS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_index_i,
  input  logic [20:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  snp_position_i,
  input  logic [1:0]                   snp_genotype_i,
  input  logic                         last_snp_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [47:0]           s_star_score_o,
  output logic [31:0]                  chosen_position_o,
  output logic [1:0]                   chosen_genotype_o,
  output logic                         none_chosen_o,
  output logic                         last_result_o
);
  import ssh_pkg::*;
  `include "s_star_haplotype_score_top_assert.svh"

  localparam int unsigned IdxW = (MAX_SNPS > 1) ? $clog2(MAX_SNPS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SNPS + 1);

  // Configuration registers.
  logic [BonusW-1:0] bonus_q;
  logic signed [PenW-1:0] pen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bonus_q <= BonusW'(5000);
      pen_q <= -PenW'(10000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BONUS: bonus_q <= cfg_data_i[BonusW-1:0];
        REG_PENALTY: pen_q <= $signed(cfg_data_i[PenW-1:0]);
        default: ;
      endcase
    end
  end

  // Memories: positions, genotypes, scores, chosen rows.
  logic [PosW-1:0] pos_mem [MAX_SNPS];
  logic [GenoW-1:0] geno_mem [MAX_SNPS];
  logic signed [ScoreW-1:0] score_mem [MAX_SNPS];
  logic [MAX_SNPS-1:0] row_mem [MAX_SNPS];

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] k_q, k_d, j_q, j_d;
  logic signed [ScoreW-1:0] sk_q, sk_d, bs_q, bs_d;
  logic [MAX_SNPS-1:0] rk_q, rk_d, brow_q, brow_d;
  logic [PosW-1:0] pk_q, pk_d, pj_q;
  logic [GenoW-1:0] gk_q, gk_d, gj_q;
  logic signed [ScoreW-1:0] sj_q;
  logic [MAX_SNPS-1:0] rj_q;
  logic signed [ScoreW-1:0] pair_q, pair_d;
  logic pvalid_q, pvalid_d;
  logic any_q, any_d;
  logic [PosW-1:0] rd_pos_q;
  logic [GenoW-1:0] rd_geno_q;

  // Memory port controls.
  logic [IdxW-1:0] rd_addr;
  logic wr_in, wr_sr;
  logic [IdxW-1:0] wr_addr;
  logic signed [ScoreW-1:0] wr_score;
  logic [MAX_SNPS-1:0] wr_row;

  // Output register. The score is held here too, so that a waiting word keeps its
  // score while the next window is already being computed.
  logic ov_q, ov_d, onone_q, onone_d, olast_q, olast_d;
  logic [PosW-1:0] opos_q, opos_d;
  logic [GenoW-1:0] ogeno_q, ogeno_d;
  logic signed [ScoreW-1:0] oscore_q, oscore_d;

  pair_t pr;
  ssh_pair_unit u_pair (
    .pos_k_i(pk_q), .pos_j_i(pj_q), .geno_k_i(gk_q), .geno_j_i(gj_q),
    .bonus_i(bonus_q), .penalty_i(pen_q), .pair_o(pr)
  );

  logic signed [ScoreW-1:0] seed;
  logic signed [ScoreW-1:0] ext;
  logic [MAX_SNPS-1:0] kbit, jbit;
  logic [IdxW-1:0] nlast;
  always_comb begin
    seed = ScoreW'(pen_q) * ScoreW'(SeedFactor);
    ext = sj_q + pair_q;
    kbit = MAX_SNPS'(1) << k_q;
    jbit = MAX_SNPS'(1) << j_q;
    nlast = IdxW'(cnt_q - CntW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (wr_in) begin
      pos_mem[wr_addr] <= snp_position_i;
      geno_mem[wr_addr] <= snp_genotype_i;
    end
    if (wr_sr) begin
      score_mem[wr_addr] <= wr_score;
      row_mem[wr_addr] <= wr_row;
    end
    pj_q <= pos_mem[rd_addr];
    gj_q <= geno_mem[rd_addr];
    sj_q <= score_mem[rd_addr];
    rj_q <= row_mem[rd_addr];
  end
  assign rd_pos_q = pj_q;
  assign rd_geno_q = gj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; j_q <= j_d; sk_q <= sk_d; bs_q <= bs_d;
    rk_q <= rk_d; brow_q <= brow_d; pk_q <= pk_d; gk_q <= gk_d;
    pair_q <= pair_d; pvalid_q <= pvalid_d; any_q <= any_d;
    onone_q <= onone_d; olast_q <= olast_d; opos_q <= opos_d; ogeno_q <= ogeno_d;
    oscore_q <= oscore_d;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; k_d = k_q; j_d = j_q;
    sk_d = sk_q; bs_d = bs_q; rk_d = rk_q; brow_d = brow_q; pk_d = pk_q; gk_d = gk_q;
    pair_d = pair_q; pvalid_d = pvalid_q; any_d = any_q;
    ov_d = ov_q; onone_d = onone_q; olast_d = olast_q; opos_d = opos_q; ogeno_d = ogeno_q;
    oscore_d = oscore_q;
    rd_addr = j_q; wr_in = 1'b0; wr_sr = 1'b0; wr_addr = k_q;
    wr_score = sk_q; wr_row = rk_q;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        wr_addr = IdxW'(cnt_q);
        if (in_valid_i) begin
          if (cnt_q < CntW'(MAX_SNPS)) begin
            wr_in = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
          if (last_snp_i) begin
            k_d = '0;
            state_d = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        // The window always holds at least one SNP here.
        wr_sr = 1'b1; wr_score = seed; wr_row = '0;
        if (k_q == nlast) begin
          k_d = '0;
          state_d = ST_RDK;
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end
      ST_RDK: begin
        // Fetch SNP k; its score is the seed.
        rd_addr = k_q;
        sk_d = seed; rk_d = '0; j_d = '0;
        state_d = (k_q == '0) ? ST_WRK : ST_RDJ;
        if (k_q == '0) state_d = (nlast == '0) ? ST_BEST : ST_RDJ;
        if (k_q == '0 && nlast != '0) begin
          k_d = IdxW'(1);
          state_d = ST_RDK;
        end
        if (k_q != '0) state_d = ST_RDJ;
      end
      ST_RDJ: begin
        // Latch SNP k data on first entry (j==0 read returned k's data).
        if (j_q == '0) begin
          pk_d = rd_pos_q; gk_d = rd_geno_q;
        end
        rd_addr = j_q;
        state_d = ST_EXT;
      end
      ST_EXT: begin
        pair_d = pr.pair; pvalid_d = pr.valid;
        state_d = ST_NEW;
      end
      ST_NEW: begin
        rd_addr = j_q;
        if (pvalid_q) begin
          if (sk_q < ext && ext >= pair_q) begin
            sk_d = ext; rk_d = rj_q | kbit;
          end else if (sk_q < pair_q) begin
            sk_d = pair_q; rk_d = jbit | kbit;
          end else if (sk_q < ext) begin
            sk_d = ext; rk_d = rj_q | kbit;
          end
        end
        if (j_q == k_q - IdxW'(1)) begin
          state_d = ST_WRK;
        end else begin
          j_d = j_q + IdxW'(1);
          state_d = ST_RDJ;
          pvalid_d = 1'b0;
        end
      end
      ST_WRK: begin
        wr_sr = 1'b1;
        if (k_q == nlast) begin
          k_d = '0;
          state_d = ST_BEST;
        end else begin
          k_d = k_q + IdxW'(1);
          state_d = ST_RDK;
        end
      end
      ST_BEST: begin
        rd_addr = k_q;
        state_d = ST_BESTCHK;
      end
      ST_BESTCHK: begin
        if (k_q == '0 || sj_q > bs_q) begin
          bs_d = sj_q; brow_d = rj_q;
        end
        if (k_q == nlast) begin
          k_d = '0; any_d = 1'b0;
          state_d = ST_EMIT_RD;
        end else begin
          k_d = k_q + IdxW'(1);
          state_d = ST_BEST;
        end
      end
      ST_EMIT_RD: begin
        rd_addr = k_q;
        if (!ov_q || out_ready_i) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // Output register is free here.
        if (brow_q[k_q]) begin
          ov_d = 1'b1; onone_d = 1'b0; opos_d = rd_pos_q; ogeno_d = rd_geno_q;
          oscore_d = bs_q;
          olast_d = ((brow_q >> k_q) >> 1) == '0;
          any_d = 1'b1;
        end
        if (k_q == nlast) begin
          if (!any_q && !brow_q[k_q]) begin
            ov_d = 1'b1; onone_d = 1'b1; olast_d = 1'b1; opos_d = '0; ogeno_d = '0;
            oscore_d = bs_q;
          end
          cnt_d = '0;
          state_d = ST_LOAD;
        end else begin
          k_d = k_q + IdxW'(1);
          state_d = ST_EMIT_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign out_valid_o = ov_q;
  assign s_star_score_o = oscore_q;
  assign chosen_position_o = opos_q;
  assign chosen_genotype_o = ogeno_q;
  assign none_chosen_o = onone_q;
  assign last_result_o = olast_q;

  `SSH_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(MAX_SNPS))
  `SSH_ASSERT(a_ready_load, clk_i, rst_ni, in_ready_o == (state_q == ST_LOAD))
  `SSH_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule
